### rtl/ssh_pkg.sv
// Shared constants for the segment/sphere hit test.
// No dependencies.
package ssh_pkg;

    localparam int COORD_WIDTH = 32;
    // register stages inside one split multiplier
    localparam int MUL_LATENCY = 2;

endpackage

### rtl/ssh_mul.sv
// Two-stage signed multiplier: four half-width partial products, then one sum.
// No dependencies; ssh_pkg::MUL_LATENCY gives its stage count to the top level.
module ssh_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                    clk,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);
    localparam int KA = AW / 2;
    localparam int KB = BW / 2;
    localparam int PW = AW + BW;

    logic signed [AW-KA-1:0] ah;
    logic signed [BW-KB-1:0] bh;
    logic        [KA-1:0]    al;
    logic        [KB-1:0]    bl;

    logic signed [AW-KA+BW-KB-1:0] ph_reg;
    logic signed [AW-KA+KB:0]      pm1_reg;
    logic signed [KA+BW-KB:0]      pm2_reg;
    logic        [KA+KB-1:0]       pl_reg;
    logic signed [PW-1:0]          p_reg;
    logic signed [PW-1:0]          p_next;

    assign ah = a[AW-1:KA];
    assign al = a[KA-1:0];
    assign bh = b[BW-1:KB];
    assign bl = b[KB-1:0];

    always_ff @(posedge clk)
    begin
        ph_reg  <= ah * bh;
        pm1_reg <= ah * $signed({1'b0, bl});
        pm2_reg <= $signed({1'b0, al}) * bh;
        pl_reg  <= al * bl;
        p_reg   <= p_next;
    end

    always_comb
    begin
        p_next = (PW'(ph_reg) <<< (KA + KB)) + (PW'(pm1_reg) <<< KA)
               + (PW'(pm2_reg) <<< KB) + PW'(pl_reg);
    end

    assign p = p_reg;

endmodule

### rtl/segment_sphere_hit_test.sv
// Segment/sphere hit test, fully pipelined top level.
// Depends on ssh_pkg and ssh_mul.
// One segment and sphere enter per cycle whenever start is high; busy stays
// low since the pipeline never stalls. The answer shows on hit with done
// high for one cycle, once the beat has passed one stage of differences,
// two multiplier stages for products and squares, one stage of sums, two
// multiplier stages for the squared cross product and r^2*|d|^2, and one
// final compare. The receiver must take every done beat as it comes.
module segment_sphere_hit_test #(
    parameter int COORD_WIDTH = ssh_pkg::COORD_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [COORD_WIDTH-1:0] start_x,
    input  logic [COORD_WIDTH-1:0] start_y,
    input  logic [COORD_WIDTH-1:0] start_z,
    input  logic [COORD_WIDTH-1:0] end_x,
    input  logic [COORD_WIDTH-1:0] end_y,
    input  logic [COORD_WIDTH-1:0] end_z,
    input  logic [COORD_WIDTH-1:0] center_x,
    input  logic [COORD_WIDTH-1:0] center_y,
    input  logic [COORD_WIDTH-1:0] center_z,
    input  logic [COORD_WIDTH-2:0] radius,
    output logic                   done,
    output logic                   hit
);
    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 2;
    localparam int CW  = PW + 1;
    localparam int QW  = 2 * CW;
    localparam int LW  = PW + SW;
    localparam int TW  = QW + 2;
    localparam int ML  = ssh_pkg::MUL_LATENCY;
    localparam int DEPTH = 2 * ML + 3;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;

    logic signed [W-1:0]  s_in [3];
    logic signed [W-1:0]  e_in [3];
    logic signed [W-1:0]  c_in [3];
    logic signed [DW-1:0] d_reg [3];
    logic signed [DW-1:0] a_reg [3];
    logic signed [DW-1:0] b_reg [3];
    logic signed [DW-1:0] r_reg;

    logic signed [PW-1:0] dsq [3];
    logic signed [PW-1:0] asq [3];
    logic signed [PW-1:0] bsq [3];
    logic signed [PW-1:0] adp [3];
    logic signed [PW-1:0] bdp [3];
    logic signed [PW-1:0] cp  [3];
    logic signed [PW-1:0] cq  [3];
    logic signed [PW-1:0] rsq;

    logic signed [SW-1:0] dd_reg, aa_reg, bb_reg, da_reg, db_reg;
    logic signed [CW-1:0] cr_reg [3];
    logic signed [PW-1:0] rr_reg;

    logic signed [QW-1:0] csq [3];
    logic signed [LW-1:0] lim;

    typedef struct packed {
        logic dd_zero;
        logic near_a;
        logic near_b;
        logic proj;
    } flags_t;

    flags_t flg_reg [ML];
    flags_t flg_next;

    logic [TW-1:0] cc_sum;
    logic          closer;
    logic          hit_reg;
    logic          hit_next;

    assign s_in = '{start_x, start_y, start_z};
    assign e_in = '{end_x, end_y, end_z};
    assign c_in = '{center_x, center_y, center_z};

    assign busy     = 1'b0;
    assign vld_next = {vld_reg[DEPTH-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // differences
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_reg[i] <= DW'(e_in[i]) - DW'(s_in[i]);
            a_reg[i] <= DW'(c_in[i]) - DW'(s_in[i]);
            b_reg[i] <= DW'(c_in[i]) - DW'(e_in[i]);
        end
        r_reg <= $signed({2'b00, radius});
    end

    // first multiplier rank
    for (genvar i = 0; i < 3; i++)
    begin : g_mul1
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        ssh_mul #(.AW(DW), .BW(DW)) u_dsq (.clk(clk), .a(d_reg[i]), .b(d_reg[i]), .p(dsq[i]));
        ssh_mul #(.AW(DW), .BW(DW)) u_asq (.clk(clk), .a(a_reg[i]), .b(a_reg[i]), .p(asq[i]));
        ssh_mul #(.AW(DW), .BW(DW)) u_bsq (.clk(clk), .a(b_reg[i]), .b(b_reg[i]), .p(bsq[i]));
        ssh_mul #(.AW(DW), .BW(DW)) u_adp (.clk(clk), .a(a_reg[i]), .b(d_reg[i]), .p(adp[i]));
        ssh_mul #(.AW(DW), .BW(DW)) u_bdp (.clk(clk), .a(b_reg[i]), .b(d_reg[i]), .p(bdp[i]));
        ssh_mul #(.AW(DW), .BW(DW)) u_cp  (.clk(clk), .a(d_reg[J]), .b(a_reg[K]), .p(cp[i]));
        ssh_mul #(.AW(DW), .BW(DW)) u_cq  (.clk(clk), .a(d_reg[K]), .b(a_reg[J]), .p(cq[i]));
    end

    ssh_mul #(.AW(DW), .BW(DW)) u_rsq (.clk(clk), .a(r_reg), .b(r_reg), .p(rsq));

    // sums of squares, dot products, cross product
    always_ff @(posedge clk)
    begin
        dd_reg <= SW'(dsq[0]) + SW'(dsq[1]) + SW'(dsq[2]);
        aa_reg <= SW'(asq[0]) + SW'(asq[1]) + SW'(asq[2]);
        bb_reg <= SW'(bsq[0]) + SW'(bsq[1]) + SW'(bsq[2]);
        da_reg <= SW'(adp[0]) + SW'(adp[1]) + SW'(adp[2]);
        db_reg <= SW'(bdp[0]) + SW'(bdp[1]) + SW'(bdp[2]);
        for (int i = 0; i < 3; i++)
        begin
            cr_reg[i] <= CW'(cp[i]) - CW'(cq[i]);
        end
        rr_reg <= rsq;
    end

    // second multiplier rank
    for (genvar i = 0; i < 3; i++)
    begin : g_mul2
        ssh_mul #(.AW(CW), .BW(CW)) u_csq (.clk(clk), .a(cr_reg[i]), .b(cr_reg[i]), .p(csq[i]));
    end

    ssh_mul #(.AW(PW), .BW(SW)) u_lim (.clk(clk), .a(rr_reg), .b(dd_reg), .p(lim));

    // side conditions ride along with the second rank
    always_comb
    begin
        flg_next.dd_zero = (dd_reg == '0);
        flg_next.near_a  = $unsigned(aa_reg) < $unsigned(SW'(rr_reg));
        flg_next.near_b  = $unsigned(bb_reg) < $unsigned(SW'(rr_reg));
        flg_next.proj    = (da_reg == '0) || (db_reg == '0)
                         || (da_reg[SW-1] != db_reg[SW-1]);
    end

    always_ff @(posedge clk)
    begin
        flg_reg[0] <= flg_next;
        for (int i = 1; i < ML; i++)
        begin
            flg_reg[i] <= flg_reg[i-1];
        end
    end

    always_comb
    begin
        cc_sum = TW'($unsigned(csq[0])) + TW'($unsigned(csq[1]))
               + TW'($unsigned(csq[2]));
        closer = cc_sum < TW'($unsigned(lim));
        if (flg_reg[ML-1].dd_zero)
        begin
            hit_next = flg_reg[ML-1].near_a;
        end
        else
        begin
            hit_next = closer && (flg_reg[ML-1].proj || flg_reg[ML-1].near_a
                                  || flg_reg[ML-1].near_b);
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign done = vld_reg[DEPTH-1];
    assign hit  = hit_reg;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, DEPTH))
        else $error("done without a start beat");

    a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(radius == '0, DEPTH) |-> !hit)
        else $error("hit on zero radius");

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> vld_reg[0])
        else $error("start beat dropped");
`endif

endmodule

### verif/tb_segment_sphere_hit_test.sv
// Testbench for segment_sphere_hit_test: directed and random segment/sphere beats,
// each hit checked against an exact wide-integer prediction. Depends on ssh_pkg.
`timescale 1ns / 1ps
module tb_segment_sphere_hit_test;

    localparam int CW = ssh_pkg::COORD_WIDTH;
    localparam int PIPE_DEPTH = 7;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [255:0] wide_t;
    typedef struct {
        logic [CW-1:0] sx, sy, sz, ex, ey, ez, cx, cy, cz;
        logic [CW-2:0] rad;
    } seg_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [CW-1:0] start_x, start_y, start_z, end_x, end_y, end_z;
    logic [CW-1:0] center_x, center_y, center_z;
    logic [CW-2:0] radius;
    logic done;
    logic hit;

    bit expected_hits[$];
    int n_errors;
    longint n_cycles;

    segment_sphere_hit_test u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .end_x(end_x), .end_y(end_y), .end_z(end_z),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .radius(radius), .done(done), .hit(hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic wide_t sx256(logic [CW-1:0] v);
        return wide_t'(signed'(v));
    endfunction

    function automatic bit touches(seg_t s);
        wide_t dx, dy, dz, ax, ay, az, bx, by, bz, rr, dd, aa, bb;
        wide_t c0, c1, c2, cc, da, db;
        dx = sx256(s.ex) - sx256(s.sx);
        dy = sx256(s.ey) - sx256(s.sy);
        dz = sx256(s.ez) - sx256(s.sz);
        ax = sx256(s.cx) - sx256(s.sx);
        ay = sx256(s.cy) - sx256(s.sy);
        az = sx256(s.cz) - sx256(s.sz);
        bx = sx256(s.cx) - sx256(s.ex);
        by = sx256(s.cy) - sx256(s.ey);
        bz = sx256(s.cz) - sx256(s.ez);
        rr = wide_t'(s.rad) * wide_t'(s.rad);
        dd = dx * dx + dy * dy + dz * dz;
        aa = ax * ax + ay * ay + az * az;
        bb = bx * bx + by * by + bz * bz;
        if (dd == 0)
            return aa < rr;
        c0 = dy * az - dz * ay;
        c1 = dz * ax - dx * az;
        c2 = dx * ay - dy * ax;
        cc = c0 * c0 + c1 * c1 + c2 * c2;
        if (!(cc < rr * dd))
            return 1'b0;
        da = ax * dx + ay * dy + az * dz;
        db = bx * dx + by * dy + bz * dz;
        // centre projects onto the closed segment when signs differ or one is zero
        if (da == 0 || db == 0 || ((da > 0) != (db > 0)))
            return 1'b1;
        return (aa < rr) || (bb < rr);
    endfunction

    function automatic int short_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // gap idle cycles, then one beat; start stays high so a zero gap runs back to back
    task automatic send_segment(seg_t s, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        start_x <= s.sx; start_y <= s.sy; start_z <= s.sz;
        end_x <= s.ex; end_y <= s.ey; end_z <= s.ez;
        center_x <= s.cx; center_y <= s.cy; center_z <= s.cz;
        radius <= s.rad;
        do @(posedge clk); while (busy);
        expected_hits.push_back(touches(s));
    endtask

    function automatic logic [CW-1:0] rnd_coord(int mode);
        case (mode)
            0: return CW'($urandom);
            1: return CW'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
            2: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            default: return CW'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic seg_t rnd_segment();
        seg_t s;
        int mode;
        mode = $urandom_range(0, 9);
        mode = (mode < 2) ? 0 : (mode < 8) ? 1 : (mode < 9) ? 2 : 3;
        s.sx = rnd_coord(mode); s.sy = rnd_coord(mode); s.sz = rnd_coord(mode);
        s.ex = rnd_coord(mode); s.ey = rnd_coord(mode); s.ez = rnd_coord(mode);
        s.cx = rnd_coord(mode); s.cy = rnd_coord(mode); s.cz = rnd_coord(mode);
        case ($urandom_range(0, 5))
            0: s.rad = (CW-1)'($urandom);
            1: s.rad = '0;
            2: s.rad = {(CW-1){1'b1}};
            default: s.rad = (CW-1)'($urandom_range(0, 32'h0010_0000));
        endcase
        if ($urandom_range(0, 15) == 0)
        begin
            s.ex = s.sx; s.ey = s.sy; s.ez = s.sz;
        end
        return s;
    endfunction

    function automatic seg_t mk(int sx, int sy, int sz, int ex, int ey, int ez,
                                int cx, int cy, int cz, int rad);
        seg_t s;
        s.sx = CW'(sx); s.sy = CW'(sy); s.sz = CW'(sz);
        s.ex = CW'(ex); s.ey = CW'(ey); s.ez = CW'(ez);
        s.cx = CW'(cx); s.cy = CW'(cy); s.cz = CW'(cz); s.rad = (CW-1)'(rad);
        return s;
    endfunction

    task automatic test_directed();
        logic [CW-1:0] mx, mn;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        send_segment(mk(0, 0, 0, 10, 0, 0, 5, 3, 0, 4), 0);     // crosses middle
        send_segment(mk(0, 0, 0, 10, 0, 0, 5, 4, 0, 4), 1);     // tangent: miss
        send_segment(mk(0, 0, 0, 10, 0, 0, 5, 5, 0, 4), 0);     // clear miss
        send_segment(mk(0, 0, 0, 10, 0, 0, 13, 0, 0, 4), 0);    // end inside
        send_segment(mk(0, 0, 0, 10, 0, 0, -3, 0, 0, 4), 2);    // start inside
        send_segment(mk(0, 0, 0, 10, 0, 0, 14, 0, 0, 4), 0);    // end on surface
        send_segment(mk(0, 0, 0, 10, 0, 0, 20, 0, 0, 4), 0);    // beyond end
        send_segment(mk(5, 5, 5, 5, 5, 5, 6, 5, 5, 2), 0);      // zero length inside
        send_segment(mk(5, 5, 5, 5, 5, 5, 7, 5, 5, 2), 0);      // zero length on surface
        send_segment(mk(0, 0, 0, 10, 0, 0, 5, 0, 0, 0), 0);     // zero radius
        send_segment(mk(0, 0, 0, 10, 0, 0, 0, 0, 0, 1), 0);     // projection at start
        send_segment(mk(mn, mn, mn, mx, mx, mx, 0, 0, 0, mx), 3);
        send_segment(mk(mx, mx, mx, mn, mn, mn, mx, mn, mx, mx), 0);
        send_segment(mk(mn, mn, mn, mn, mn, mn, mx, mx, mx, mx), 0);
        send_segment(mk(mx, mn, mx, mx, mn, mx, mx, mn, mx, 1), 0);
        send_segment(mk(-1, -1, -1, 1, 1, 1, 0, 0, 0, {(CW-1){1'b1}}), 0);
        send_segment(mk(mn, 0, 0, mx, 0, 0, 0, mx, 0, mx), 0);
        send_segment(mk(mn, 0, 0, mx, 0, 0, 0, mx, 0, 0), 0);
    endtask

    task automatic test_random_gaps(int count);
        repeat (count) send_segment(rnd_segment(), short_gap());
    endtask

    task automatic test_back_to_back(int count);
        repeat (count) send_segment(rnd_segment(), 0);
    endtask

    task automatic test_near_surface(int count);
        seg_t s;
        int r;
        repeat (count)
        begin
            r = $urandom_range(1, 64);
            s = mk(-100, $urandom_range(0, 2 * r) - r, $urandom_range(0, 2) - 1,
                   100, $urandom_range(0, 2 * r) - r, $urandom_range(0, 2) - 1,
                   $urandom_range(0, 240) - 120, 0, 0, r);
            send_segment(s, short_gap());
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual hit=%0b",
                         $realtime, hit);
                n_errors++;
            end
            else
            begin
                bit want;
                want = expected_hits.pop_front();
                if (hit !== want)
                begin
                    $display("%0t: hit mismatch, expected %0b, actual %0b",
                             $realtime, want, hit);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", n_cycles);
            $display("tb_segment_sphere_hit_test: errors");
            $finish;
        end
    end

    initial
    begin
        n_errors = 0;
        n_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        {start_x, start_y, start_z, end_x, end_y, end_z} = '0;
        {center_x, center_y, center_z} = '0;
        radius = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_gaps(600);
        test_back_to_back(400);
        test_near_surface(400);
        start <= 1'b0;
        while (expected_hits.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 5) @(posedge clk);
        if (n_errors == 0)
            $display("tb_segment_sphere_hit_test: clean");
        else
            $display("tb_segment_sphere_hit_test: errors");
        $finish;
    end
endmodule

### segment_sphere_hit_test.f
rtl/ssh_pkg.sv
rtl/ssh_mul.sv
rtl/segment_sphere_hit_test.sv
verif/tb_segment_sphere_hit_test.sv
